/* design/sorted_priority_queue_macros.svh */
// Assertion macros shared by the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define SPQ_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

/* design/spq_pkg.sv */
`default_nettype none
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int VALUE_BITS    = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]    value;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/spq_in_if.sv */
`default_nettype none
interface spq_in_if
    import spq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [VALUE_BITS-1:0]    item_value;
    logic [PRIORITY_BITS-1:0] item_priority;

    modport source (output valid, command, item_value, item_priority, input ready);
    modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface
`default_nettype wire

/* design/spq_out_if.sv */
`default_nettype none
interface spq_out_if
    import spq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [VALUE_BITS-1:0]    front_value;
    logic [PRIORITY_BITS-1:0] front_priority;
    logic                     queue_empty;
    logic [COUNT_BITS-1:0]    entry_count;

    modport source (output valid, status, front_value, front_priority, queue_empty,
                    entry_count, input ready);
    modport sink   (input valid, status, front_value, front_priority, queue_empty,
                    entry_count, output ready);
endinterface
`default_nettype wire

/* design/spq_cell.sv */
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       le_prev,
    input  wire entry_t     new_entry,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            le
);

    entry_t entry_reg;
    entry_t entry_next;

    // The entry here stays put on insert when it is served before the new one.
    assign le = occupied && (entry_reg.prio <= new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en && !le)
        begin
            // The first cell past the stay-put run takes the new entry,
            // every later cell takes its left neighbor.
            entry_next = le_prev ? new_entry : left_entry;
        end
        else if (ctrl.remove_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

/* design/sorted_priority_queue.sv */
// Sorted priority queue of CAPACITY entries held in a row of cells, kept in
// ascending priority order with ties in arrival order. Each request is an
// insert, a remove of the front entry, or a clear; each returns one result
// with a status and the front entry, empty flag and count after the command.
// Every cell compares its priority with the new one and shifts in parallel,
// so one request is accepted per clock cycle while not stalled, and its
// result is registered in the output register; the input is stalled only while
// an earlier result waits in that register and the sink is not ready.
`default_nettype none
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    spq_in_if.sink    in_ch,
    spq_out_if.source out_ch
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               status_reg;
    status_t               status_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    logic       accept;
    logic       full;
    logic       empty;
    cmd_t       cmd;
    cell_ctrl_t ctrl;
    entry_t     new_entry;
    entry_t     cell_q [CAPACITY];
    logic       le     [CAPACITY];
    logic       front_ordered;
    logic       full_drop;
    logic       clear_accept;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cmd         = cmd_t'(in_ch.command);
    assign full        = (count_reg == COUNT_BITS'(CAPACITY));
    assign empty       = (count_reg == '0);

    assign new_entry.value = in_ch.item_value;
    assign new_entry.prio  = in_ch.item_priority;

    always_comb
    begin
        ctrl        = '0;
        status_next = status_reg;
        count_next  = count_reg;
        if (accept)
        begin
            status_next = ST_OK;
            unique case (cmd)
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.insert_en = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.remove_en = 1'b1;
                        count_next     = count_reg - 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            count_reg     <= count_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic   occupied;
            logic   le_prev;
            entry_t left_entry;
            entry_t right_entry;

            assign occupied = (COUNT_BITS'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign le_prev    = 1'b1;
                assign left_entry = new_entry;
            end
            else
            begin : g_inner
                assign le_prev    = le[i-1];
                assign left_entry = cell_q[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_entry = cell_q[i];
            end
            else
            begin : g_body
                assign right_entry = cell_q[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied),
                .le_prev     (le_prev),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (cell_q[i]),
                .le          (le[i])
            );
        end
    endgenerate

    // The cells only change on an accepted request, together with the result
    // register, so the front is read straight from the first cell.
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = status_reg;
    assign out_ch.front_value    = empty ? '0 : cell_q[0].value;
    assign out_ch.front_priority = empty ? '0 : cell_q[0].prio;
    assign out_ch.queue_empty    = empty;
    assign out_ch.entry_count    = count_reg;

    assign front_ordered = (count_reg < COUNT_BITS'(2)) || (cell_q[0].prio <= cell_q[1].prio);
    assign full_drop     = accept && cmd == CMD_INSERT && full;
    assign clear_accept  = accept && cmd == CMD_CLEAR;

    `SPQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= COUNT_BITS'(CAPACITY))
    `SPQ_ASSERT_ALWAYS(a_front_sorted, clk, rst_n, front_ordered)
    `SPQ_ASSERT_NEXT(a_full_drop, clk, rst_n, full_drop, $stable(count_reg) && status_reg == ST_FULL)
    `SPQ_ASSERT_NEXT(a_clear, clk, rst_n, clear_accept, count_reg == '0 && out_valid_reg)

endmodule
`default_nettype wire
